// ----- src/kli_pkg.sv -----
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types, sizes and codes for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int MAX_KEYS     = 64;
  localparam int MAX_ELEMENTS = 8;
  localparam int FRAC_BITS    = 16;

  localparam int KEY_AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int EL_AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int ELN_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int PS_AW  = $clog2(MAX_KEYS * MAX_ELEMENTS);
  localparam int QW     = FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(QW + 1);
  localparam int PW     = 34 + QW;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_LEN = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        key_time;
    logic signed [31:0] element_value;
    logic               element_last;
  } kli_in_t;

  typedef struct packed {
    logic signed [31:0] pose_value;
    logic [2:0]         pose_index;
    logic               result_last;
    logic [1:0]         status;
  } kli_out_t;

  typedef struct packed {
    logic              capture;
    logic              stg_write;
    logic              stg_clear;
    logic [KEY_AW-1:0] tm_addr;
    logic              tm_we;
    logic              tm_shift;
    logic [PS_AW-1:0]  ps_addr;
    logic              ps_we;
    logic              ps_shift;
    logic [EL_AW-1:0]  ps_el;
    logic              ld_prev;
    logic              ld_clamp;
    logic              div_start;
    logic              zero_f;
    logic              ld_a;
    logic              ld_prod;
    logic              emit;
    logic              emit_value;
    logic [2:0]        emit_idx;
    logic              emit_last;
    logic [1:0]        emit_status;
  } kli_cmd_t;

  typedef struct packed {
    logic cur_le;
    logic cur_lt;
    logic seg_nonzero;
    logic div_busy;
    logic stg_bad;
  } kli_sts_t;

  function automatic logic [PS_AW-1:0] pose_addr(logic [KEY_AW-1:0] key,
                                                 logic [EL_AW-1:0] el);
    logic [PS_AW+EL_AW:0] a;
    a = (PS_AW+EL_AW+1)'(key) * (PS_AW+EL_AW+1)'(MAX_ELEMENTS)
        + (PS_AW+EL_AW+1)'(el);
    return a[PS_AW-1:0];
  endfunction

endpackage

// ----- src/kli_ram.sv -----
// ----------------------------------------------------------------------------
// kli_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- src/kli_datapath.sv -----
// ----------------------------------------------------------------------------
// kli_datapath
// Key stores, staging pose, clamp and scan compares, fraction divider,
// blend multiplier and the result register.
// ----------------------------------------------------------------------------
module kli_datapath import kli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kli_in_t          in_i,
  input  logic [ELN_W-1:0] len_i,
  input  kli_cmd_t         cmd_i,
  output kli_sts_t         sts_o,
  output logic             result_valid_o,
  output kli_out_t         result_o
);

  logic [31:0]        t_q;
  logic [31:0]        prev_q;
  logic signed [31:0] stg_q [MAX_ELEMENTS];
  logic [ELN_W-1:0]   scnt_q;
  logic               sovf_q;
  logic [31:0]        tm_rdata, tm_wdata;
  logic [31:0]        ps_rdata, ps_wdata;
  logic signed [31:0] a_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] mul;
  logic               busy_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [32:0]        rem_q;
  logic [31:0]        den_q;
  logic [QW-1:0]      nlo_q;
  logic [QW-1:0]      quo_q;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        tclamp;
  logic [31:0]        dnum;
  logic signed [32:0] diff;
  logic signed [PW-1:0] acc;
  logic               valid_q;
  kli_out_t           res_q;

  kli_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
    .clk_i  (clk_i),
    .addr_i (cmd_i.tm_addr),
    .we_i   (cmd_i.tm_we),
    .wdata_i(tm_wdata),
    .rdata_o(tm_rdata)
  );

  kli_ram #(.WIDTH(32), .DEPTH(MAX_KEYS * MAX_ELEMENTS)) u_poses (
    .clk_i  (clk_i),
    .addr_i (cmd_i.ps_addr),
    .we_i   (cmd_i.ps_we),
    .wdata_i(ps_wdata),
    .rdata_o(ps_rdata)
  );

  assign tm_wdata = cmd_i.tm_shift ? tm_rdata : t_q;
  assign ps_wdata = cmd_i.ps_shift ? ps_rdata : stg_q[cmd_i.ps_el];

  assign sts_o.cur_le      = (tm_rdata <= t_q);
  assign sts_o.cur_lt      = (tm_rdata < t_q);
  assign sts_o.seg_nonzero = (tm_rdata > prev_q);
  assign sts_o.div_busy    = busy_q;
  assign sts_o.stg_bad     = sovf_q || (scnt_q != len_i);

  // clamp to [first key, last key]; last key time is on the read port
  always_comb begin
    tclamp = (t_q < prev_q) ? prev_q : t_q;
    if (tclamp > tm_rdata) begin
      tclamp = tm_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q <= in_i.key_time;
    end else if (cmd_i.ld_clamp) begin
      t_q <= tclamp;
    end
    if (cmd_i.ld_prev) begin
      prev_q <= tm_rdata;
    end
  end

  // staging pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
      sovf_q <= 1'b0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        stg_q[i] <= '0;
      end
    end else if (cmd_i.stg_clear) begin
      scnt_q <= '0;
      sovf_q <= 1'b0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        stg_q[i] <= '0;
      end
    end else if (cmd_i.stg_write) begin
      if (scnt_q < len_i) begin
        stg_q[scnt_q[EL_AW-1:0]] <= in_i.element_value;
        scnt_q <= scnt_q + ELN_W'(1);
      end else begin
        sovf_q <= 1'b1;
      end
    end
  end

  // restoring divider: f = ((t - t0) << FRAC_BITS) / (t1 - t0), one bit a cycle
  assign dnum  = t_q - prev_q;
  assign trial = {rem_q[31:0], nlo_q[QW-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      dcnt_q <= DCNT_W'(QW);
    end else if (busy_q) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
      if (dcnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= {2'b00, dnum[31:1]};
      nlo_q <= {dnum[0], {(QW-1){1'b0}}};
      den_q <= tm_rdata - prev_q;
      quo_q <= '0;
    end else if (cmd_i.zero_f) begin
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? (trial - {1'b0, den_q}) : trial;
      nlo_q <= {nlo_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], qbit};
    end
  end

  // blend: a + (b - a) * f, rounded half up
  assign diff = $signed({ps_rdata[31], ps_rdata}) - $signed({a_q[31], a_q});
  assign mul  = diff * $signed({1'b0, quo_q});
  assign acc  = ($signed(PW'(a_q)) <<< FRAC_BITS) + prod_q
                + $signed(PW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      a_q <= ps_rdata;
    end
    if (cmd_i.ld_prod) begin
      prod_q <= mul;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.pose_value  <= cmd_i.emit_value ? acc[FRAC_BITS+31:FRAC_BITS] : '0;
      res_q.pose_index  <= cmd_i.emit_idx;
      res_q.result_last <= cmd_i.emit_last;
      res_q.status      <= cmd_i.emit_status;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

// ----- src/kli_ctrl.sv -----
// ----------------------------------------------------------------------------
// kli_ctrl
// Sequencer for load, sorted insert, query scan, divide and element emit.
// ----------------------------------------------------------------------------
module kli_ctrl import kli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  kli_in_t          in_i,
  input  logic [ELN_W-1:0] len_i,
  input  kli_sts_t         sts_i,
  output logic             busy_o,
  output kli_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LD_CHK  = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_SH_RD   = 4'd4;
  localparam logic [3:0] S_SH_WR   = 4'd5;
  localparam logic [3:0] S_INS_WR  = 4'd6;
  localparam logic [3:0] S_Q_RD0   = 4'd7;
  localparam logic [3:0] S_Q_RDN   = 4'd8;
  localparam logic [3:0] S_Q_CLAMP = 4'd9;
  localparam logic [3:0] S_Q_SRD   = 4'd10;
  localparam logic [3:0] S_Q_SCMP  = 4'd11;
  localparam logic [3:0] S_DIV     = 4'd12;
  localparam logic [3:0] S_E_RDA   = 4'd13;
  localparam logic [3:0] S_E_RDB   = 4'd14;
  localparam logic [3:0] S_E_OUT   = 4'd15;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  sh_q, sh_d;
  logic [KEY_AW-1:0] lo_q, lo_d;
  logic [EL_AW-1:0]  el_q, el_d;
  logic              mul_q, mul_d;
  logic              el_end;
  logic              accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign el_end = (el_q == EL_AW'(MAX_ELEMENTS - 1));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    sh_d    = sh_q;
    lo_d    = lo_q;
    el_d    = el_q;
    mul_d   = 1'b0;
    cmd_o   = '0;
    cmd_o.ps_el = el_q;
    cmd_o.emit_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          case (in_i.req_type)
            REQ_LOAD: begin
              cmd_o.stg_write = 1'b1;
              if (in_i.element_last) begin
                state_d = S_LD_CHK;
              end
            end
            REQ_QUERY: begin
              if (count_q == '0) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                state_d = S_Q_RD0;
              end
            end
            REQ_CLEAR: begin
              count_d         = '0;
              cmd_o.stg_clear = 1'b1;
              cmd_o.emit      = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_LD_CHK: begin
        if (sts_i.stg_bad || count_q >= CNT_W'(MAX_KEYS)) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = sts_i.stg_bad ? ST_BAD_LEN : ST_FULL;
          cmd_o.stg_clear   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          idx_d   = '0;
          state_d = S_INS_RD;
        end
      end

      // find the first key later than the new time
      S_INS_RD: begin
        cmd_o.tm_addr = idx_q[KEY_AW-1:0];
        if (idx_q == count_q) begin
          sh_d    = count_q;
          el_d    = '0;
          state_d = S_SH_RD;
        end else begin
          state_d = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (sts_i.cur_le) begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_INS_RD;
        end else begin
          sh_d    = count_q;
          el_d    = '0;
          state_d = S_SH_RD;
        end
      end

      // move keys above the slot up by one, one word at a time
      S_SH_RD: begin
        if (sh_q == idx_q) begin
          el_d    = '0;
          state_d = S_INS_WR;
        end else begin
          cmd_o.tm_addr = KEY_AW'(sh_q - CNT_W'(1));
          cmd_o.ps_addr = pose_addr(KEY_AW'(sh_q - CNT_W'(1)), el_q);
          state_d       = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cmd_o.tm_addr  = sh_q[KEY_AW-1:0];
        cmd_o.tm_we    = 1'b1;
        cmd_o.tm_shift = 1'b1;
        cmd_o.ps_addr  = pose_addr(sh_q[KEY_AW-1:0], el_q);
        cmd_o.ps_we    = 1'b1;
        cmd_o.ps_shift = 1'b1;
        if (el_end) begin
          el_d = '0;
          sh_d = sh_q - CNT_W'(1);
        end else begin
          el_d = el_q + EL_AW'(1);
        end
        state_d = S_SH_RD;
      end

      S_INS_WR: begin
        cmd_o.tm_addr = idx_q[KEY_AW-1:0];
        cmd_o.tm_we   = 1'b1;
        cmd_o.ps_addr = pose_addr(idx_q[KEY_AW-1:0], el_q);
        cmd_o.ps_we   = 1'b1;
        if (el_end) begin
          count_d         = count_q + CNT_W'(1);
          cmd_o.emit      = 1'b1;
          cmd_o.stg_clear = 1'b1;
          state_d         = S_IDLE;
        end else begin
          el_d = el_q + EL_AW'(1);
        end
      end

      S_Q_RD0: begin
        cmd_o.tm_addr = '0;
        state_d       = S_Q_RDN;
      end

      S_Q_RDN: begin
        cmd_o.tm_addr = KEY_AW'(count_q - CNT_W'(1));
        cmd_o.ld_prev = 1'b1;
        state_d       = S_Q_CLAMP;
      end

      S_Q_CLAMP: begin
        cmd_o.ld_clamp = 1'b1;
        el_d           = '0;
        if (count_q == CNT_W'(1)) begin
          lo_d         = '0;
          idx_d        = '0;
          cmd_o.zero_f = 1'b1;
          state_d      = S_E_RDA;
        end else begin
          idx_d   = CNT_W'(1);
          state_d = S_Q_SRD;
        end
      end

      S_Q_SRD: begin
        cmd_o.tm_addr = idx_q[KEY_AW-1:0];
        state_d       = S_Q_SCMP;
      end

      S_Q_SCMP: begin
        if (idx_q < count_q - CNT_W'(1) && sts_i.cur_lt) begin
          cmd_o.ld_prev = 1'b1;
          idx_d         = idx_q + CNT_W'(1);
          state_d       = S_Q_SRD;
        end else begin
          lo_d = KEY_AW'(idx_q - CNT_W'(1));
          if (sts_i.seg_nonzero) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            // zero-length segment: take the left key
            idx_d        = idx_q - CNT_W'(1);
            cmd_o.zero_f = 1'b1;
            state_d      = S_E_RDA;
          end
        end
      end

      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_E_RDA;
        end
      end

      S_E_RDA: begin
        cmd_o.ps_addr = pose_addr(lo_q, el_q);
        state_d       = S_E_RDB;
      end

      S_E_RDB: begin
        cmd_o.ld_a    = 1'b1;
        cmd_o.ps_addr = pose_addr(idx_q[KEY_AW-1:0], el_q);
        mul_d         = 1'b1;
        state_d       = S_E_OUT;
      end

      // with mul_q set it forms the product, else it emits
      S_E_OUT: begin
        if (mul_q) begin
          cmd_o.ld_prod = 1'b1;
        end else begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_value = 1'b1;
          cmd_o.emit_idx   = 3'(el_q);
          cmd_o.emit_last  = (ELN_W'(el_q) + ELN_W'(1) == len_i);
          if (cmd_o.emit_last) begin
            state_d = S_IDLE;
          end else begin
            el_d    = el_q + EL_AW'(1);
            state_d = S_E_RDA;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      sh_q    <= '0;
      lo_q    <= '0;
      el_q    <= '0;
      mul_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      sh_q    <= sh_d;
      lo_q    <= lo_d;
      el_q    <= el_d;
      mul_q   <= mul_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("key count above table size");

  a_shift_above_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SH_WR |-> sh_q > idx_q)
    else $error("shift writes at or below insert slot");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.req_type == REQ_CLEAR |=> count_q == '0)
    else $error("clear left keys in table");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && cmd_o.emit_value && cmd_o.emit_last |=> state_q == S_IDLE)
    else $error("final element did not end the query");

endmodule

// ----- src/keyframe_linear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit
// Sorted keyframe table with piecewise linear Q16.16 pose interpolation.
// ----------------------------------------------------------------------------
// Raise start_i with a request on req_i; it is taken when busy_o is low.
// A load element that is not last is staged, gives no result and leaves
// busy_o low. A last element checks the pose length and the table, scans
// the lower keys to find the slot, moves every higher key up one word at
// a time and writes the new key word by word; one status result follows.
// A query reads the first and last key times, scans the keys, divides for
// a segment of nonzero length and then gives the elements one at a time.
// The single ported key stores set this step-by-step order. A clear or an
// empty-table query answers in the cycle after acceptance. Results appear
// on result_o for one cycle with result_valid_o high; the receiver cannot
// stall them. cfg_we_i writes pose_length; the user must write it only
// while idle, and the block itself does not enforce this.
// Reset empties the table and the staging pose, and sets pose_length to 8.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit import kli_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  kli_in_t    req_i,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  output logic       result_valid_o,
  output kli_out_t   result_o
);

  logic [3:0]       pose_len_q;
  logic [ELN_W-1:0] used_len;
  kli_cmd_t         cmd;
  kli_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_len_q <= 4'd8;
    end else if (cfg_we_i) begin
      pose_len_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the pose size as the pose size
  always_comb begin
    if (pose_len_q == 4'd0) begin
      used_len = ELN_W'(1);
    end else if (32'(pose_len_q) > MAX_ELEMENTS) begin
      used_len = ELN_W'(MAX_ELEMENTS);
    end else begin
      used_len = ELN_W'(pose_len_q);
    end
  end

  kli_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .in_i   (req_i),
    .len_i  (used_len),
    .sts_i  (sts),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  kli_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (req_i),
    .len_i         (used_len),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// ----- sim/keyframe_linear_interpolator_unit_test.sv -----
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_unit_test
// Self-checking bench for the keyframe interpolator: a scoreboard keeps its
// own keyframe table, predicts every status and interpolated pose element,
// and compares each result strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_unit_test;
  import kli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_IGNORED = 2'd3;

  class kli_scoreboard;
    logic [31:0]        key_time_tbl[MAX_KEYS];
    logic signed [31:0] key_pose_tbl[MAX_KEYS][MAX_ELEMENTS];
    int                 key_cnt;
    logic signed [31:0] stage_pose[MAX_ELEMENTS];
    int                 stage_cnt;
    bit                 stage_ovf;
    logic [3:0]         pose_len;
    kli_out_t           pending[$];
    int                 errors;

    function new();
      pose_len = 4'd8;
      key_cnt  = 0;
      errors   = 0;
      clear_stage();
    endfunction

    function void clear_stage();
      foreach (stage_pose[i]) stage_pose[i] = '0;
      stage_cnt = 0;
      stage_ovf = 0;
    endfunction

    function int eff_len();
      if (pose_len == 0) return 1;
      if (pose_len > MAX_ELEMENTS) return MAX_ELEMENTS;
      return int'(pose_len);
    endfunction

    function void push(logic signed [31:0] v, int idx, bit last, logic [1:0] st);
      kli_out_t r;
      r.pose_value  = v;
      r.pose_index  = 3'(idx);
      r.result_last = last;
      r.status      = st;
      pending.insert(pending.size(), r);
    endfunction

    // Weighted sum with round half up; the floor shift keeps it exact.
    function logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                       longint f);
      longint sum;
      sum = longint'(a) * ((64'sd1 << FRAC_BITS) - f) + longint'(b) * f;
      sum = (sum + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return sum[31:0];
    endfunction

    function void note_request(kli_in_t r);
      int len, pos, lo, hi;
      logic [31:0] t;
      longint unsigned num, den, f;
      len = eff_len();
      case (r.req_type)
        REQ_LOAD: begin
          if (stage_cnt < len) begin
            stage_pose[stage_cnt] = r.element_value;
            stage_cnt++;
          end else begin
            stage_ovf = 1;
          end
          if (!r.element_last) return;
          if (stage_ovf || stage_cnt != len) begin
            push('0, 0, 1'b1, ST_BAD_LEN);
          end else if (key_cnt >= MAX_KEYS) begin
            push('0, 0, 1'b1, ST_FULL);
          end else begin
            pos = 0;
            while (pos < key_cnt && key_time_tbl[pos] <= r.key_time) pos++;
            for (int i = key_cnt; i > pos; i--) begin
              key_time_tbl[i] = key_time_tbl[i-1];
              key_pose_tbl[i] = key_pose_tbl[i-1];
            end
            key_time_tbl[pos] = r.key_time;
            key_pose_tbl[pos] = stage_pose;
            key_cnt++;
            push('0, 0, 1'b1, ST_OK);
          end
          clear_stage();
        end
        REQ_CLEAR: begin
          key_cnt = 0;
          clear_stage();
          push('0, 0, 1'b1, ST_OK);
        end
        REQ_QUERY: begin
          if (key_cnt == 0) begin
            push('0, 0, 1'b1, ST_EMPTY);
            return;
          end
          t = r.key_time;
          if (t < key_time_tbl[0]) t = key_time_tbl[0];
          if (t > key_time_tbl[key_cnt-1]) t = key_time_tbl[key_cnt-1];
          lo = 0;
          hi = 0;
          f  = 0;
          if (key_cnt >= 2) begin
            hi = 1;
            while (hi < key_cnt - 1 && key_time_tbl[hi] < t) hi++;
            lo = hi - 1;
            if (key_time_tbl[hi] > key_time_tbl[lo]) begin
              num = longint'(t - key_time_tbl[lo]) << FRAC_BITS;
              den = longint'(key_time_tbl[hi] - key_time_tbl[lo]);
              f = num / den;
              if (f > (64'd1 << FRAC_BITS)) f = 64'd1 << FRAC_BITS;
            end else begin
              hi = lo;
            end
          end
          for (int e = 0; e < len; e++)
            push(blend(key_pose_tbl[lo][e], key_pose_tbl[hi][e], f), e, e + 1 == len,
                 ST_OK);
        end
        default: ;
      endcase
    endfunction

    function void check_result(kli_out_t r);
      kli_out_t x;
      if (pending.size() == 0) begin
        $error("unexpected result: value %0d index %0d last %0b status %0d",
               r.pose_value, r.pose_index, r.result_last, r.status);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (r.pose_value !== x.pose_value) begin
        $error("pose_value: expected %0d actual %0d", x.pose_value, r.pose_value);
        errors++;
      end
      if (r.pose_index !== x.pose_index) begin
        $error("pose_index: expected %0d actual %0d", x.pose_index, r.pose_index);
        errors++;
      end
      if (r.result_last !== x.result_last) begin
        $error("result_last: expected %0b actual %0b", x.result_last, r.result_last);
        errors++;
      end
      if (r.status !== x.status) begin
        $error("status: expected %0d actual %0d", x.status, r.status);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  kli_in_t    req_i;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       result_valid_o;
  kli_out_t   result_o;

  kli_scoreboard pose_sb = new();
  int burst_left = 0;
  int sent_items = 0;

  keyframe_linear_interpolator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) pose_sb.check_result(result_o);
  end

  // Present one request and hold it until the block takes it.
  task automatic send(kli_in_t item);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= item;
    do @(posedge clk_i); while (busy_o);
    pose_sb.note_request(item);
    sent_items++;
  endtask

  task automatic send_fields(logic [1:0] rt, logic [31:0] t, logic [31:0] v, bit last);
    kli_in_t item;
    item.req_type      = rt;
    item.key_time      = t;
    item.element_value = v;
    item.element_last  = last;
    send(item);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 8'hff)) - 128) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  // Send n pose elements, all carrying the key time, the last one marked.
  task automatic load_pose(int n, logic [31:0] t);
    for (int i = 0; i < n; i++) send_fields(REQ_LOAD, t, rand_value(), i == n - 1);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pose_sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // Write pose_length only once the block has gone quiet, then empty the table.
  task automatic set_pose_len(logic [3:0] v);
    drain();
    repeat (40) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pose_sb.pose_len = v;
    send_fields(REQ_CLEAR, '0, '0, 1'b0);
  endtask

  task automatic random_phase(logic [3:0] plen, int n_items);
    int len, sel, start_count;
    set_pose_len(plen);
    len = pose_sb.eff_len();
    start_count = sent_items;
    while (sent_items - start_count < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        load_pose(len, rand_time());
      end else if (sel < 63) begin
        // pose of random length: too long, or from one element up to the pose length
        load_pose($urandom_range(0, 1) ? len + $urandom_range(1, 3)
                                       : $urandom_range(1, len), rand_time());
      end else if (sel < 92) begin
        send_fields(REQ_QUERY, rand_time(), $urandom, 1'($urandom_range(0, 1)));
      end else if (sel < 95) begin
        send_fields(REQ_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_fields(REQ_IGNORED, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty query, ignored request, extremes, sorted insert, bad lengths
    send_fields(REQ_QUERY, 32'd5, '0, 1'b0);
    send_fields(REQ_IGNORED, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    for (int i = 0; i < 8; i++)
      send_fields(REQ_LOAD, 32'd100, i[0] ? 32'h7fff_ffff : 32'h8000_0000, i == 7);
    load_pose(8, 32'd100);
    load_pose(8, 32'd0);
    load_pose(3, 32'd50);
    load_pose(9, 32'd60);
    load_pose(8, 32'hffff_ffff);
    send_fields(REQ_QUERY, 32'd0, '0, 1'b0);
    send_fields(REQ_QUERY, 32'd37, '0, 1'b0);
    send_fields(REQ_QUERY, 32'd100, '0, 1'b0);
    send_fields(REQ_QUERY, 32'h8000_0000, '0, 1'b0);
    send_fields(REQ_QUERY, 32'hffff_ffff, '0, 1'b0);
    send_fields(REQ_CLEAR, '0, '0, 1'b0);
    send_fields(REQ_QUERY, 32'd7, '0, 1'b0);

    // fill the table to overflow with single-element poses
    set_pose_len(4'd1);
    for (int i = 0; i <= MAX_KEYS; i++) load_pose(1, 32'(i * 3));
    send_fields(REQ_QUERY, 32'd50, '0, 1'b0);

    random_phase(4'd0, 20);
    random_phase(4'd2, 25);
    random_phase(4'd8, 25);
    random_phase(4'd15, 20);
    random_phase(4'd5, 25);
    random_phase(4'd3, 20);

    drain();
    repeat (60) @(posedge clk_i);
    if (pose_sb.errors == 0 && pose_sb.pending.size() == 0) begin
      $display("keyframe_linear_interpolator_unit_test: PASS");
    end else begin
      $display("keyframe_linear_interpolator_unit_test: FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("keyframe_linear_interpolator_unit_test: FAIL");
    $finish;
  end

endmodule
